FILE: hdl/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_WBIT  = 3'd2,
    PH_WACK  = 3'd3,
    PH_RBIT  = 3'd4,
    PH_RACK  = 3'd5,
    PH_STOP  = 3'd6
  } phase_t;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_READ  = 3'd2;
  localparam logic [2:0] ACT_WRRD  = 3'd3;
  localparam logic [2:0] ACT_PUSH  = 3'd4;

  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_WRRD  = 2'd3;

  // One result beat.
  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic [7:0] byte_count;
    logic       addr_acked;
    logic       busy_res;
  } result_t;

endpackage

FILE: hdl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer stepped by slot ticks.
// Input channel (in_valid/in_ready): each beat carries an action: a tick
// (one bus delay slot, with in_sda_sample the SDA level at the slot's end),
// a start command (write, read, write-then-read) or a write-buffer push.
// Result channel (out_valid/out_ready): exactly one beat per input beat with
// the SCL level, SDA latch, SDA drive enable, a received byte when one
// completes, and the done flag with byte count and address ACK.
// The sequencer state and the result register update at the edge that
// accepts the beat. Throughput is one beat per cycle; the single result
// register limits it, and a new beat is taken in the same cycle the held
// result is taken.
// When the receiver stalls, the held result stays and in_ready drops until
// it is taken. Reset puts the bus idle with SCL and SDA driven high and the
// write buffer empty; buffer contents are undefined until pushed.
// Commands other than ticks are ignored while a transfer is running.
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
#(
  parameter int WRITE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic       in_sda_sample,
  input  logic [6:0] in_target_addr,
  input  logic [7:0] in_push_byte,
  input  logic [4:0] in_write_count,
  input  logic [7:0] in_read_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl,
  output logic       out_sda_level,
  output logic       out_sda_drive,
  output logic       out_read_valid,
  output logic [7:0] out_read_data,
  output logic       out_done_res,
  output logic [7:0] out_byte_count,
  output logic       out_addr_acked,
  output logic       out_busy_res
);

  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int FW = $clog2(WRITE_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(WRITE_DEPTH);

  phase_t     phase_r, phase_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       scl_r, scl_nxt, sda_r, sda_nxt, drv_r, drv_nxt;
  logic       abyte_r, abyte_nxt, aok_r, aok_nxt;
  logic [7:0] wbuf [WRITE_DEPTH];

  logic       fire, full, buf_we;
  logic       rvalid, done, scl_rep, drv_rep;
  logic [7:0] rdata, rshift, buf_byte;
  logic [7:0] wc_min;
  result_t    res;

  assign in_ready = !full || out_ready;
  assign fire = in_valid && in_ready;

  // Buffer read; out-of-range positions read as zero.
  assign buf_byte = ({1'b0, pos_r} < 9'(WRITE_DEPTH)) ? wbuf[pos_r[AW-1:0]] : 8'h00;
  assign wc_min = ({4'b0, in_write_count} < 9'(fill_r)) ? {3'b0, in_write_count}
                                                         : 8'(fill_r);
  assign rshift = {shift_r[6:0], in_sda_sample};

  // Write buffer storage.
  always_ff @(posedge clk) begin
    if (fire && buf_we) begin
      wbuf[fill_r[AW-1:0]] <= in_push_byte;
    end
  end

  // Sequencer next state, one slot per tick.
  always_comb begin
    phase_nxt = phase_r; slot_nxt = slot_r; bit_nxt = bit_r;
    shift_nxt = shift_r; fill_nxt = fill_r; pos_nxt = pos_r;
    left_nxt = left_r; pend_nxt = pend_r; kind_nxt = kind_r;
    addr_nxt = addr_r; cnt_nxt = cnt_r; scl_nxt = scl_r;
    sda_nxt = sda_r; drv_nxt = drv_r; abyte_nxt = abyte_r; aok_nxt = aok_r;
    rvalid = 1'b0; rdata = 8'h00; done = 1'b0; buf_we = 1'b0;
    scl_rep = scl_r; drv_rep = drv_r;
    if (phase_r == PH_IDLE) begin
      if (in_action == ACT_WRITE || in_action == ACT_READ || in_action == ACT_WRRD) begin
        kind_nxt = in_action[1:0];
        addr_nxt = in_target_addr;
        cnt_nxt = 8'h00; aok_nxt = 1'b0; pos_nxt = 8'h00; left_nxt = 8'h00;
        pend_nxt = (in_action != ACT_WRITE) ? in_read_count : 8'h00;
        if (in_action != ACT_READ) begin
          left_nxt = wc_min;
          fill_nxt = '0;
        end
        phase_nxt = PH_START; slot_nxt = 2'd0; bit_nxt = 3'd0;
      end else if (in_action == ACT_PUSH && fill_r < DEPTH_F) begin
        buf_we = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end else if (in_action == ACT_TICK) begin
      unique case (phase_r)
        PH_START: begin
          unique case (slot_r)
            2'd0: sda_nxt = 1'b1;
            2'd1: scl_nxt = 1'b1;
            2'd2: sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
          if (slot_r == 2'd3) begin
            shift_nxt = {addr_r, kind_r == KIND_READ};
            abyte_nxt = 1'b1;
            phase_nxt = PH_WBIT; slot_nxt = 2'd0; bit_nxt = 3'd0;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
        PH_WBIT: begin
          if (slot_r == 2'd0) begin
            scl_nxt = 1'b0; scl_rep = 1'b0; slot_nxt = 2'd1;
          end else if (slot_r == 2'd1) begin
            sda_nxt = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            slot_nxt = 2'd2;
          end else begin
            scl_nxt = 1'b1; scl_rep = 1'b1; slot_nxt = 2'd0;
            if (bit_r == 3'd7) begin
              phase_nxt = PH_WACK; bit_nxt = 3'd0;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        PH_WACK: begin
          if (slot_r == 2'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; slot_nxt = 2'd1;
            scl_rep = 1'b0;
          end else begin
            // Reported pins: SCL high, SDA released; then SCL low, driving.
            scl_rep = 1'b1; drv_rep = 1'b0;
            scl_nxt = 1'b0; drv_nxt = 1'b1;
            slot_nxt = 2'd0; bit_nxt = 3'd0;
            if (abyte_r) aok_nxt = !in_sda_sample;
            if (abyte_r && in_sda_sample) begin
              cnt_nxt = 8'h00; phase_nxt = PH_STOP;
            end else if (abyte_r && kind_r == KIND_READ) begin
              if (pend_r == 8'h00) begin
                phase_nxt = PH_STOP;
              end else begin
                shift_nxt = 8'h00; phase_nxt = PH_RBIT;
              end
            end else if (in_sda_sample || left_r == 8'h00) begin
              // End of the write stage.
              if (kind_r == KIND_WRRD) begin
                if (pend_r == 8'h00) begin
                  cnt_nxt = 8'h00; phase_nxt = PH_STOP;
                end else begin
                  kind_nxt = KIND_READ; phase_nxt = PH_START;
                end
              end else begin
                phase_nxt = PH_STOP;
              end
            end else begin
              shift_nxt = buf_byte;
              pos_nxt = pos_r + 8'd1;
              left_nxt = left_r - 8'd1;
              if (kind_r == KIND_WRITE) cnt_nxt = cnt_r + 8'd1;
              abyte_nxt = 1'b0;
              phase_nxt = PH_WBIT;
            end
          end
        end
        PH_RBIT: begin
          if (slot_r == 2'd0) begin
            scl_nxt = 1'b0; drv_nxt = 1'b0; slot_nxt = 2'd1;
            scl_rep = 1'b0; drv_rep = 1'b0;
          end else begin
            scl_rep = 1'b1; scl_nxt = 1'b1;
            shift_nxt = rshift; slot_nxt = 2'd0;
            if (bit_r == 3'd7) begin
              rvalid = 1'b1; rdata = rshift;
              cnt_nxt = cnt_r + 8'd1;
              if (pend_r != 8'h00) pend_nxt = pend_r - 8'd1;
              scl_nxt = 1'b0; drv_nxt = 1'b1;
              phase_nxt = PH_RACK; bit_nxt = 3'd0;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        PH_RACK: begin
          if (slot_r == 2'd0) begin
            scl_nxt = 1'b0; slot_nxt = 2'd1; scl_rep = 1'b0;
          end else if (slot_r == 2'd1) begin
            sda_nxt = (pend_r == 8'h00); slot_nxt = 2'd2;
          end else begin
            scl_nxt = 1'b1; scl_rep = 1'b1; slot_nxt = 2'd0; bit_nxt = 3'd0;
            if (pend_r == 8'h00) begin
              phase_nxt = PH_STOP;
            end else begin
              shift_nxt = 8'h00; phase_nxt = PH_RBIT;
            end
          end
        end
        PH_STOP: begin
          unique case (slot_r)
            2'd0: begin scl_nxt = 1'b0; scl_rep = 1'b0; end
            2'd1: sda_nxt = 1'b0;
            2'd2: begin scl_nxt = 1'b1; scl_rep = 1'b1; end
            default: sda_nxt = 1'b1;
          endcase
          if (slot_r == 2'd3) begin
            done = 1'b1;
            phase_nxt = PH_IDLE; slot_nxt = 2'd0; bit_nxt = 3'd0;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
        default: ;
      endcase
      if (phase_r == PH_START) scl_rep = scl_nxt;
    end
  end

  // Result beat; pins are reported before any deferred release.
  always_comb begin
    res.scl        = scl_rep;
    res.sda_level  = sda_nxt;
    res.sda_drive  = drv_rep;
    res.read_valid = rvalid;
    res.read_data  = rdata;
    res.done_res   = done;
    res.byte_count = done ? cnt_nxt : 8'h00;
    res.addr_acked = done && aok_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; slot_r <= 2'd0; bit_r <= 3'd0; shift_r <= 8'h00;
      fill_r <= '0; pos_r <= 8'h00; left_r <= 8'h00; pend_r <= 8'h00;
      kind_r <= 2'd0; addr_r <= 7'h00; cnt_r <= 8'h00;
      scl_r <= 1'b1; sda_r <= 1'b1; drv_r <= 1'b1;
      abyte_r <= 1'b0; aok_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; slot_r <= slot_nxt; bit_r <= bit_nxt;
      shift_r <= shift_nxt; fill_r <= fill_nxt; pos_r <= pos_nxt;
      left_r <= left_nxt; pend_r <= pend_nxt; kind_r <= kind_nxt;
      addr_r <= addr_nxt; cnt_r <= cnt_nxt;
      scl_r <= scl_nxt; sda_r <= sda_nxt; drv_r <= drv_nxt;
      abyte_r <= abyte_nxt; aok_r <= aok_nxt;
    end
  end

  result_t dout;

  i2cm_out_reg u_out (
    .clk  (clk),
    .rst_n(rst_n),
    .load (fire),
    .din  (res),
    .full (full),
    .take (out_ready),
    .dout (dout)
  );

  assign out_valid      = full;
  assign out_scl        = dout.scl;
  assign out_sda_level  = dout.sda_level;
  assign out_sda_drive  = dout.sda_drive;
  assign out_read_valid = dout.read_valid;
  assign out_read_data  = dout.read_data;
  assign out_done_res   = dout.done_res;
  assign out_byte_count = dout.byte_count;
  assign out_addr_acked = dout.addr_acked;
  assign out_busy_res   = dout.busy_res;

  // A finished transfer always reports not busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done beat reports busy");

  // A stalled result beat holds until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_count))
    else $error("stalled result lost");

  // The buffer fill never exceeds its depth.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= DEPTH_F)
    else $error("write buffer overfilled");

endmodule

FILE: hdl/i2cm_out_reg.sv
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t din,
  output logic    full,
  input  logic    take,
  output result_t dout
);

  logic    full_r;
  result_t data_r;

  // Result register: loads whenever a new beat is produced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (load) begin
      full_r <= 1'b1;
    end else if (take) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign full = full_r;
  assign dout = data_r;

endmodule
